### hw/rtl/grid_astar_path_finder_macros.svh
// Assertion macros shared by the path finder RTL.
// Every macro samples on clock and is held off while reset is high.
`ifndef GRID_ASTAR_PATH_FINDER_MACROS_SVH
`define GRID_ASTAR_PATH_FINDER_MACROS_SVH

// Same-cycle implication.
`define GAP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GAP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/gap_pkg.sv
// Shared types and constants of the grid path finder.
// No dependencies.
`default_nettype none

package gap_pkg;

   // 8.8 fixed-point costs
   localparam int COST_W = 16;
   localparam logic [COST_W-1:0] FX_STRAIGHT   = 16'd256;
   localparam logic [COST_W-1:0] FX_DIAG       = 16'd362;
   localparam logic [COST_W-1:0] FX_DIAG_EXTRA = 16'd106;
   localparam logic [COST_W-1:0] COST_INF      = 16'hFFFF;
   localparam logic [COST_W-1:0] COST_MAX      = 16'hFFFE;

   // result list bound
   localparam int MAX_RESULTS = 64;

   // CSR map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ABORT_LIMIT = 2'd2;
   localparam logic [6:0] RST_GRID_WIDTH  = 7'd64;
   localparam logic [6:0] RST_GRID_HEIGHT = 7'd64;
   localparam logic [9:0] RST_ABORT_LIMIT = 10'd1000;

   // open queue commands and status
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } q_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic full;
   } q_stat_type;

   typedef enum logic [1:0] {
      Q_IDLE,
      Q_SCAN,
      Q_SHIFT
   } q_state_type;

   // search sequencer
   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_NB_SEL,
      S_NB_EVAL,
      S_POP,
      S_POP_WT,
      S_CUR_RD,
      S_CUR_LD,
      S_TR_CHK,
      S_TR_EV,
      S_EM_RD,
      S_EM_LD,
      S_EM_WT,
      S_FAIL
   } srch_state_type;

endpackage

`default_nettype wire

### hw/rtl/grid_astar_path_finder.sv
// Channel | Dir | Handshake            | Beat
// req     | in  | req_valid/req_stall  | source and target cell of one query
// rsp     | out | rsp_valid/rsp_stall  | one path cell, or one failure mark
// csr     | in  | csr_write_en         | one register write
//
// One query at a time; req_stall stays high from acceptance to the last beat.
// Each query opens with a sweep of the node memory, during which no query is taken.
// Each pop scans and then shifts the open list; each neighbour is read from the node
// memory and written back when its new f cost is lower than the stored one.
// Each path cell is traced (S_TR_CHK, S_TR_EV), then emitted (S_EM_RD, S_EM_LD,
// S_EM_WT), waiting in S_EM_WT while rsp_stall is high.
// Reset is synchronous; queue and sequencer return to idle.
`default_nettype none
`include "grid_astar_path_finder_macros.svh"

module grid_astar_path_finder import gap_pkg::*; #(
   parameter int GRID_DIM   = 64,
   parameter int HEAP_DEPTH = 1024,
   parameter int PATH_DEPTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [5:0]            req_source_col,
   input  wire logic [5:0]            req_source_row,
   input  wire logic [5:0]            req_target_col,
   input  wire logic [5:0]            req_target_row,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [5:0]                 rsp_step_col,
   output logic [5:0]                 rsp_step_row,
   output logic                       rsp_found,
   output logic                       rsp_last_step,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int CW  = $clog2(GRID_DIM);
   localparam int CI  = 2 * CW;
   localparam int PW  = ((CW > 7) ? CW : 7) + 2;
   localparam int HW  = PW + 9;
   localparam int NDW = 2 * COST_W + 1 + CI;
   localparam int LIM = (PATH_DEPTH < MAX_RESULTS) ? PATH_DEPTH : MAX_RESULTS;
   localparam int SA  = $clog2(LIM);
   localparam int NW  = $clog2(LIM + 1);
   localparam int QCW = $clog2(HEAP_DEPTH + 1);

   typedef struct packed {
      logic [PW-1:0]     w;
      logic [PW-1:0]     h;
      logic [PW-1:0]     tc;
      logic [PW-1:0]     tr;
      logic [PW-1:0]     col;
      logic [PW-1:0]     row;
      logic [COST_W-1:0] cur_g;
      logic              has_cur;
      logic              cur_lv;
      logic [CI-1:0]     cur_link;
      logic [CI-1:0]     cur_idx;
      logic [1:0]        dx;
      logic [1:0]        dy;
      logic [CI-1:0]     nidx;
      logic [COST_W-1:0] ng;
      logic [COST_W-1:0] nf;
      logic [CI-1:0]     path_p;
      logic [NW-1:0]     n;
      logic [SA-1:0]     e;
   } ctx_type;

   srch_state_type state_ff, state_in;
   ctx_type ctx_ff, ctx_in;

   // CSRs
   logic [6:0] grid_width_ff, grid_height_ff;
   logic [9:0] abort_limit_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [5:0] rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic       rsp_found_ff, rsp_found_in, rsp_last_ff, rsp_last_in;

   // node memory port
   logic           node_clr, node_busy, node_rd_en, node_wr_en;
   logic [CI-1:0]  node_rd_addr, node_wr_addr;
   logic [NDW-1:0] node_rd_data, node_wr_data;
   logic [COST_W-1:0] nd_f, nd_g;
   logic           nd_lv;
   logic [CI-1:0]  nd_link;

   // open queue port
   q_cmd_type      q_cmd;
   q_stat_type     q_stat;
   logic [QCW-1:0] q_count;
   logic [CI-1:0]  q_pop_cell;

   // path stack
   logic [CI-1:0] stack [LIM];
   logic [CI-1:0] stk_rd_ff;
   logic          stk_wr_en, stk_rd_en;

   // neighbour datapath
   logic signed [PW-1:0] nc_s, nr_s, adx_s, ady_s;
   logic [PW-1:0]     adx, ady, hi, lo;
   logic [HW-1:0]     hcost;
   logic [HW:0]       f_sum;
   logic [COST_W:0]   g_sum;
   logic [COST_W-1:0] ng, nf;
   logic              nb_center, nb_diag, nb_in, nb_last, nb_skip, ev_skip;
   logic [CI-1:0]     nidx;
   logic              accept, pop_hit, abort;
   logic [PW-1:0]     w_ext, h_ext;

   assign accept = req_valid && !req_stall;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= RST_GRID_WIDTH;
         grid_height_ff <= RST_GRID_HEIGHT;
         abort_limit_ff <= RST_ABORT_LIMIT;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_write_data[6:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_write_data[6:0];
            CSR_ABORT_LIMIT: abort_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // node entry fields
   assign nd_f    = node_rd_data[NDW-1 -: COST_W];
   assign nd_g    = node_rd_data[NDW-1-COST_W -: COST_W];
   assign nd_lv   = node_rd_data[CI];
   assign nd_link = node_rd_data[CI-1:0];

   // neighbour cell, bounds and octile costs
   always_comb begin
      w_ext = PW'(grid_width_ff);
      h_ext = PW'(grid_height_ff);
      nc_s  = $signed(ctx_ff.col) + $signed(PW'(ctx_ff.dx)) - PW'(1);
      nr_s  = $signed(ctx_ff.row) + $signed(PW'(ctx_ff.dy)) - PW'(1);
      nb_center = (ctx_ff.dx == 2'd1) && (ctx_ff.dy == 2'd1);
      nb_diag   = (ctx_ff.dx != 2'd1) && (ctx_ff.dy != 2'd1);
      nb_last   = (ctx_ff.dx == 2'd2) && (ctx_ff.dy == 2'd2);
      nb_in     = (nc_s >= 0) && (nc_s < $signed(ctx_ff.w)) &&
                  (nr_s >= 0) && (nr_s < $signed(ctx_ff.h));
      nb_skip   = nb_center || !nb_in;
      nidx      = {nr_s[CW-1:0], nc_s[CW-1:0]};
      adx_s = $signed(ctx_ff.tc) - nc_s;
      ady_s = $signed(ctx_ff.tr) - nr_s;
      adx   = (adx_s < 0) ? PW'(-adx_s) : PW'(adx_s);
      ady   = (ady_s < 0) ? PW'(-ady_s) : PW'(ady_s);
      hi    = (adx > ady) ? adx : ady;
      lo    = (adx > ady) ? ady : adx;
      hcost = (HW'(hi) << 8) + HW'(lo) * HW'(FX_DIAG_EXTRA);
      g_sum = {1'b0, ctx_ff.cur_g} + {1'b0, (nb_diag ? FX_DIAG : FX_STRAIGHT)};
      ng    = (g_sum > {1'b0, COST_MAX}) ? COST_MAX : g_sum[COST_W-1:0];
      f_sum = (HW+1)'(hcost) + (HW+1)'(ng);
      nf    = (f_sum > (HW+1)'(COST_MAX)) ? COST_MAX : f_sum[COST_W-1:0];
      ev_skip = (nd_f <= ctx_ff.nf) ||
                (ctx_ff.has_cur && ctx_ff.cur_lv && (ctx_ff.cur_link == ctx_ff.nidx));
      pop_hit = (PW'(q_pop_cell[CW-1:0]) == ctx_ff.tc) &&
                (PW'(q_pop_cell[CI-1:CW]) == ctx_ff.tr);
      abort   = ((QCW > 10) ? q_count > QCW'(abort_limit_ff)
                            : 10'(q_count) > abort_limit_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (accept) state_in = S_CLEAR;
         S_CLEAR:   if (!node_busy) state_in = S_NB_SEL;
         S_NB_SEL:  if (!nb_skip) state_in = S_NB_EVAL;
                    else if (nb_last) state_in = S_POP;
         S_NB_EVAL: if (!ev_skip && q_stat.full) state_in = S_FAIL;
                    else state_in = nb_last ? S_POP : S_NB_SEL;
         S_POP:     state_in = (q_count == '0) ? S_FAIL : S_POP_WT;
         S_POP_WT:  if (q_stat.done) begin
                       if (abort) state_in = S_FAIL;
                       else if (pop_hit) state_in = S_TR_CHK;
                       else state_in = S_CUR_RD;
                    end
         S_CUR_RD:  state_in = S_CUR_LD;
         S_CUR_LD:  state_in = S_NB_SEL;
         S_TR_CHK:  state_in = (ctx_ff.n >= NW'(LIM)) ? S_FAIL : S_TR_EV;
         S_TR_EV:   state_in = nd_lv ? S_TR_CHK : S_EM_RD;
         S_EM_RD:   state_in = S_EM_LD;
         S_EM_LD:   state_in = S_EM_WT;
         S_EM_WT:   if (!rsp_stall) state_in = rsp_last_ff ? S_IDLE : S_EM_RD;
         S_FAIL:    state_in = S_EM_WT;
         default:   state_in = S_IDLE;
      endcase
   end

   // memory, queue and handshake controls
   always_comb begin
      req_stall    = (state_ff != S_IDLE);
      node_clr     = 1'b0;
      node_rd_en   = 1'b0;
      node_rd_addr = nidx;
      node_wr_en   = 1'b0;
      node_wr_addr = ctx_ff.nidx;
      node_wr_data = {ctx_ff.nf, ctx_ff.ng, ctx_ff.has_cur,
                      ctx_ff.has_cur ? ctx_ff.cur_idx : {CI{1'b0}}};
      q_cmd        = '0;
      stk_wr_en    = 1'b0;
      stk_rd_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            node_clr    = accept;
            q_cmd.clear = accept;
         end
         S_NB_SEL:  node_rd_en = !nb_skip;
         S_NB_EVAL: begin
            node_wr_en = !ev_skip;
            q_cmd.push = !ev_skip && !q_stat.full;
         end
         S_POP:     q_cmd.pop = (q_count != '0);
         S_CUR_RD: begin
            node_rd_en   = 1'b1;
            node_rd_addr = ctx_ff.cur_idx;
         end
         S_TR_CHK: begin
            node_rd_en   = 1'b1;
            node_rd_addr = ctx_ff.path_p;
            stk_wr_en    = (ctx_ff.n < NW'(LIM));
         end
         S_EM_RD:   stk_rd_en = 1'b1;
         default: ;
      endcase
   end

   // search context
   always_comb begin
      ctx_in = ctx_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            ctx_in.w       = (w_ext > PW'(GRID_DIM)) ? PW'(GRID_DIM) : w_ext;
            ctx_in.h       = (h_ext > PW'(GRID_DIM)) ? PW'(GRID_DIM) : h_ext;
            ctx_in.col     = PW'(req_source_col);
            ctx_in.row     = PW'(req_source_row);
            ctx_in.tc      = PW'(req_target_col);
            ctx_in.tr      = PW'(req_target_row);
            ctx_in.cur_g   = '0;
            ctx_in.has_cur = 1'b0;
            ctx_in.cur_lv  = 1'b0;
            ctx_in.cur_idx = '0;
            ctx_in.dx      = 2'd0;
            ctx_in.dy      = 2'd0;
         end
         S_NB_SEL, S_NB_EVAL: begin
            if (state_ff == S_NB_SEL) begin
               ctx_in.nidx = nidx;
               ctx_in.ng   = ng;
               ctx_in.nf   = nf;
            end
            // step to the next neighbour once this one is settled
            if ((state_ff == S_NB_EVAL) || nb_skip) begin
               if (ctx_ff.dx == 2'd2) begin
                  ctx_in.dx = 2'd0;
                  ctx_in.dy = ctx_ff.dy + 2'd1;
               end else begin
                  ctx_in.dx = ctx_ff.dx + 2'd1;
               end
            end
         end
         S_POP_WT: if (q_stat.done) begin
            ctx_in.cur_idx = q_pop_cell;
            ctx_in.path_p  = q_pop_cell;
            ctx_in.n       = '0;
         end
         S_CUR_LD: begin
            ctx_in.cur_g    = nd_g;
            ctx_in.cur_lv   = nd_lv;
            ctx_in.cur_link = nd_link;
            ctx_in.has_cur  = 1'b1;
            ctx_in.col      = PW'(ctx_ff.cur_idx[CW-1:0]);
            ctx_in.row      = PW'(ctx_ff.cur_idx[CI-1:CW]);
            ctx_in.dx       = 2'd0;
            ctx_in.dy       = 2'd0;
         end
         S_TR_CHK: if (ctx_ff.n < NW'(LIM)) ctx_in.n = ctx_ff.n + 1'b1;
         S_TR_EV: begin
            if (nd_lv) ctx_in.path_p = nd_link;
            else ctx_in.e = SA'(ctx_ff.n - 1'b1);
         end
         S_EM_WT: if (!rsp_stall && !rsp_last_ff) ctx_in.e = ctx_ff.e - 1'b1;
         default: ;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_EM_LD: begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = 6'(stk_rd_ff[CW-1:0]);
            rsp_row_in   = 6'(stk_rd_ff[CI-1:CW]);
            rsp_found_in = 1'b1;
            rsp_last_in  = (ctx_ff.e == '0);
         end
         S_FAIL: begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = '0;
            rsp_row_in   = '0;
            rsp_found_in = 1'b0;
            rsp_last_in  = 1'b1;
         end
         S_EM_WT: if (!rsp_stall) rsp_valid_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ctx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctx_ff       <= ctx_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_found_ff <= rsp_found_in;
   end

   // path stack storage
   always_ff @(posedge clock) begin
      if (stk_wr_en) stack[ctx_ff.n[SA-1:0]] <= ctx_ff.path_p;
      if (stk_rd_en) stk_rd_ff <= stack[ctx_ff.e];
   end

   gap_node_mem #(
      .AW (CI),
      .DW (NDW)
   ) u_node_mem (
      .clock       (clock),
      .reset       (reset),
      .clear_start (node_clr),
      .busy        (node_busy),
      .rd_en       (node_rd_en),
      .rd_addr     (node_rd_addr),
      .rd_data     (node_rd_data),
      .wr_en       (node_wr_en),
      .wr_addr     (node_wr_addr),
      .wr_data     (node_wr_data)
   );

   gap_open_queue #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .CELL_W     (CI)
   ) u_open_queue (
      .clock     (clock),
      .reset     (reset),
      .cmd       (q_cmd),
      .push_cell (ctx_ff.nidx),
      .push_key  (ctx_ff.nf),
      .stat      (q_stat),
      .count     (q_count),
      .pop_cell  (q_pop_cell)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_step_col  = rsp_col_ff;
   assign rsp_step_row  = rsp_row_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_last_step = rsp_last_ff;

   `GAP_ASSERT_NXT(a_start, accept, state_ff == S_CLEAR, "query did not start with clear")
   `GAP_ASSERT_IMP(a_rsp_state, rsp_valid_ff, state_ff == S_EM_WT, "beat shown outside wait")
   `GAP_ASSERT_IMP(a_path_bound, state_ff == S_TR_EV, ctx_ff.n <= NW'(LIM), "path stack overrun")
   `GAP_ASSERT_IMP(a_pop_idle, q_cmd.pop, !q_stat.busy && !node_busy, "pop while queue busy")

endmodule

`default_nettype wire

### hw/rtl/gap_node_mem.sv
// Per-cell cost and back-link memory with a clearing sweep.
// Depends on gap_pkg.
`default_nettype none

module gap_node_mem import gap_pkg::*; #(
   parameter int AW = 12,
   parameter int DW = 45
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          clear_start,
   output logic               busy,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [DW-1:0]      rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);

   // f and g at infinity, no link
   localparam logic [DW-1:0] CLEAR_WORD = {{(2*COST_W){1'b1}}, {(DW-2*COST_W){1'b0}}};

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_data_ff;
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // sweep one entry per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_start) begin
         clr_busy_in = 1'b1;
         clr_addr_in = '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == {AW{1'b1}}) clr_busy_in = 1'b0;
         clr_addr_in = clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (clr_busy_ff) mem[clr_addr_ff] <= CLEAR_WORD;
      else if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign busy    = clr_busy_ff;
   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/gap_open_queue.sv
// Open list: insertion-ordered memory, pop of the earliest smallest key
// by a linear scan followed by a shift-down. Depends on gap_pkg, macros.
`default_nettype none
`include "grid_astar_path_finder_macros.svh"

module gap_open_queue import gap_pkg::*; #(
   parameter int HEAP_DEPTH = 1024,
   parameter int CELL_W     = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire q_cmd_type         cmd,
   input  wire logic [CELL_W-1:0] push_cell,
   input  wire logic [COST_W-1:0] push_key,
   output q_stat_type             stat,
   output logic [$clog2(HEAP_DEPTH+1)-1:0] count,
   output logic [CELL_W-1:0]      pop_cell
);

   localparam int HA  = $clog2(HEAP_DEPTH);
   localparam int QCW = $clog2(HEAP_DEPTH+1);
   localparam int QDW = CELL_W + COST_W;

   logic [QDW-1:0] mem [HEAP_DEPTH];
   logic [QDW-1:0] rd_data_ff;

   q_state_type state_ff, state_in;
   logic [QCW-1:0]    count_ff, count_in;
   logic [QCW-1:0]    idx_ff, idx_in;
   logic [QCW-1:0]    best_ff, best_in;
   logic [COST_W-1:0] best_key_ff, best_key_in;
   logic [CELL_W-1:0] best_cell_ff, best_cell_in;
   logic              pend_ff, pend_in;
   logic [HA-1:0]     wa_ff, wa_in;
   logic              done_ff, done_in;

   logic              full, more, scan_end, shift_end, rd_en, wr_en;
   logic [HA-1:0]     wr_addr;
   logic [QDW-1:0]    wr_data;
   logic [COST_W-1:0] rd_key;

   assign full      = (count_ff == QCW'(HEAP_DEPTH));
   assign more      = (idx_ff < count_ff);
   assign scan_end  = (state_ff == Q_SCAN) && (idx_ff == count_ff);
   assign shift_end = (state_ff == Q_SHIFT) && !more && !pend_ff;
   assign rd_key    = rd_data_ff[COST_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         Q_IDLE:  if (cmd.pop) state_in = Q_SCAN;
         Q_SCAN:  if (scan_end) state_in = Q_SHIFT;
         Q_SHIFT: if (shift_end) state_in = Q_IDLE;
         default: state_in = Q_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      wr_en   = 1'b0;
      wr_addr = count_ff[HA-1:0];
      wr_data = {push_cell, push_key};
      case (state_ff)
         Q_IDLE: wr_en = cmd.push && !full;
         Q_SCAN: rd_en = more;
         Q_SHIFT: begin
            rd_en   = more;
            wr_en   = pend_ff;
            wr_addr = wa_ff;
            wr_data = rd_data_ff;
         end
         default: ;
      endcase
   end

   // scan, shift and count bookkeeping
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_key_in  = best_key_ff;
      best_cell_in = best_cell_ff;
      pend_in      = 1'b0;
      wa_in        = wa_ff;
      done_in      = 1'b0;
      case (state_ff)
         Q_IDLE: begin
            if (cmd.clear) count_in = '0;
            else if (cmd.push && !full) count_in = count_ff + 1'b1;
            idx_in = '0;
         end
         Q_SCAN: begin
            // data of entry idx-1 is on the read port
            if (idx_ff != '0 && (idx_ff == QCW'(1) || rd_key < best_key_ff)) begin
               best_in      = idx_ff - 1'b1;
               best_key_in  = rd_key;
               best_cell_in = rd_data_ff[QDW-1:COST_W];
            end
            idx_in = scan_end ? best_in + 1'b1 : idx_ff + 1'b1;
         end
         Q_SHIFT: begin
            pend_in = more;
            wa_in   = HA'(idx_ff - 1'b1);
            if (more) idx_in = idx_ff + 1'b1;
            if (shift_end) begin
               count_in = count_ff - 1'b1;
               done_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
      end
      best_ff      <= best_in;
      best_key_ff  <= best_key_in;
      best_cell_ff <= best_cell_in;
      wa_ff        <= wa_in;
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[idx_ff[HA-1:0]];
   end

   assign stat.busy = (state_ff != Q_IDLE);
   assign stat.done = done_ff;
   assign stat.full = full;
   assign count     = count_ff;
   assign pop_cell  = best_cell_ff;

   `GAP_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= QCW'(HEAP_DEPTH), "queue count past depth")
   `GAP_ASSERT_IMP(a_push_idle, cmd.push, (state_ff == Q_IDLE) && !full, "push while busy or full")
   `GAP_ASSERT_NXT(a_pop_dec, shift_end, (count_ff + 1'b1) == $past(count_ff), "pop lost count")
   `GAP_ASSERT_IMP(a_scan_nonempty, state_ff == Q_SCAN, count_ff != '0, "scan of empty queue")

endmodule

`default_nettype wire
